/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the position threshold table.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define WPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define WPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/wpt_pkg.sv */
// Types and constants of the wrapped position threshold table.
// No dependencies; used by every RTL module of the block.
package wpt_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int IDX_IN_W    = 4;
    localparam int POS_W       = 32;
    localparam int SUM_W       = POS_W + 1;
    localparam int DIV_STEPS   = SUM_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);
    localparam int PADDR_W     = 3;
    localparam int S_DATA_W    = 104;
    localparam int M_DATA_W    = 40;

    localparam logic [PADDR_W-1:0] REG_MEAS_RANGE_ADDR = 3'd0;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_CHECK = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_INVALID       = 2'd1,
        STATUS_NOT_PERMITTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] threshold;
        logic             wrap;
        logic             trig;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           entry;
    } tbl_wr_t;

endpackage

/* rtl/wpt_modulo.sv */
// Bit-serial restoring remainder unit: 33-bit dividend mod 32-bit divisor.
// One quotient bit per cycle; depends on wpt_pkg.
module wpt_modulo
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wpt_pkg::SUM_W-1:0]   dividend,
    input  logic [wpt_pkg::POS_W-1:0]   divisor,
    output logic                        done,
    output logic [wpt_pkg::POS_W-1:0]   remainder
);

    logic                        run_reg,  run_next;
    logic                        done_reg, done_next;
    logic [wpt_pkg::CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [wpt_pkg::SUM_W-1:0]   dq_reg,   dq_next;
    logic [wpt_pkg::POS_W-1:0]   rem_reg,  rem_next;
    logic [wpt_pkg::SUM_W-1:0]   trial;
    logic [wpt_pkg::SUM_W-1:0]   diff;

    // shift the next dividend bit in, subtract the divisor if it fits
    assign trial = {rem_reg, dq_reg[wpt_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dq_next  = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            dq_next  = {dq_reg[wpt_pkg::SUM_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? diff[wpt_pkg::POS_W-1:0]
                                                  : trial[wpt_pkg::POS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == wpt_pkg::CNT_W'(wpt_pkg::DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/wpt_table.sv */
// Threshold entry store: one write port, one combinational read port.
// Flip-flop array cleared at reset; depends on wpt_pkg.
module wpt_table
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  wpt_pkg::tbl_wr_t            wr,
    input  logic [wpt_pkg::IDX_W-1:0]   raddr,
    output wpt_pkg::entry_t             rdata
);

    wpt_pkg::entry_t store_reg [wpt_pkg::NUM_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wpt_pkg::NUM_ENTRIES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            store_reg[wr.addr] <= wr.entry;
        end
    end

    assign rdata = store_reg[raddr];

endmodule

/* rtl/wrapped_position_threshold_table.sv */
// Top level of the wrapped position threshold table: APB register, item
// sequencer and output register. Depends on wpt_pkg, wpt_table, wpt_modulo.
//
// A set item stores (start_position + offset) mod meas_range as an entry's
// threshold and marks wrap-pending if the 33-bit sum reached the range; a
// check item raises the trigger once the position reaches the threshold (or,
// with wrap pending, waits for the position to drop below it and clears the
// mark); a clear item drops the trigger. One word is in flight at a time:
// s_tready is high only while the sequencer is idle. A set whose sum reaches
// the range runs the bit-serial remainder unit, one bit per cycle over 33
// bits, and the next word is taken only after it has finished; every other
// word passes from execute straight to response. The result sits in an
// output register, so the next input word is taken while a result waits for
// m_tready. Results come back in input order, one per word. The store is
// cleared by reset, no sweep is needed. meas_range is at byte address 0; a
// zero range answers every word with status not permitted.
`include "assert_macros.svh"

module wrapped_position_threshold_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wpt_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[3:0], start_position[35:4], offset[67:36],
    // position[99:68], zero pad[103:100]
    input  logic [wpt_pkg::S_DATA_W-1:0]    s_tdata,
    // kind[1:0]
    input  logic [1:0]                      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], triggered[2], wrap_pending[3], threshold[35:4], zero pad[39:36]
    output logic [wpt_pkg::M_DATA_W-1:0]    m_tdata
);

    // configuration
    logic [wpt_pkg::POS_W-1:0]      meas_range_reg;
    logic                           cfg_wr;

    // sequencer
    wpt_pkg::state_t                state_reg, state_next;

    // latched item
    logic [1:0]                     kind_reg;
    logic [wpt_pkg::IDX_IN_W-1:0]   idx_reg;
    logic [wpt_pkg::SUM_W-1:0]      sum_reg;
    logic [wpt_pkg::POS_W-1:0]      offs_reg;
    logic [wpt_pkg::POS_W-1:0]      pos_reg;

    // result waiting for the output register
    wpt_pkg::status_t               res_status_reg, res_status_next;
    wpt_pkg::entry_t                res_entry_reg,  res_entry_next;

    // output register
    logic                           out_valid_reg;
    logic [wpt_pkg::M_DATA_W-1:0]   out_data_reg;

    // decision made in the execute cycle
    wpt_pkg::status_t               exec_status;
    wpt_pkg::entry_t                exec_entry;
    logic                           exec_write;
    logic                           exec_div;
    logic                           idx_ok;

    // control outputs of the sequencer
    logic                           accept;
    logic                           div_start;
    logic                           load_res;
    logic                           load_out;
    logic                           out_free;
    wpt_pkg::tbl_wr_t               tbl_wr;

    wpt_pkg::entry_t                tbl_rdata;
    logic                           div_done;
    logic [wpt_pkg::POS_W-1:0]      div_rem;

    //------------------------------------------------------------------
    // APB register
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == wpt_pkg::REG_MEAS_RANGE_ADDR);
    assign prdata = (paddr == wpt_pkg::REG_MEAS_RANGE_ADDR) ? meas_range_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_range_reg <= '0;
        end
        else if (cfg_wr)
        begin
            meas_range_reg <= pwdata;
        end
    end

    //------------------------------------------------------------------
    // Entry store and remainder unit
    //------------------------------------------------------------------
    wpt_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .raddr (idx_reg[wpt_pkg::IDX_W-1:0]),
        .rdata (tbl_rdata)
    );

    wpt_modulo u_modulo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sum_reg),
        .divisor   (meas_range_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    //------------------------------------------------------------------
    // Item decision, from the latched word and the addressed entry
    //------------------------------------------------------------------
    assign idx_ok = {1'b0, idx_reg} < (wpt_pkg::IDX_IN_W + 1)'(wpt_pkg::NUM_ENTRIES);

    always_comb
    begin
        exec_status = wpt_pkg::STATUS_NOT_PERMITTED;
        exec_entry  = '0;
        exec_write  = 1'b0;
        exec_div    = 1'b0;
        if ((meas_range_reg != '0) && idx_ok)
        begin
            unique case (kind_reg)
                wpt_pkg::KIND_SET:
                begin
                    exec_entry = tbl_rdata;
                    if (offs_reg >= meas_range_reg)
                    begin
                        exec_status = wpt_pkg::STATUS_INVALID;
                    end
                    else if (sum_reg >= {1'b0, meas_range_reg})
                    begin
                        // wrapped sum: remainder unit finishes the job
                        exec_status = wpt_pkg::STATUS_OK;
                        exec_div    = 1'b1;
                    end
                    else
                    begin
                        exec_status          = wpt_pkg::STATUS_OK;
                        exec_entry.threshold = sum_reg[wpt_pkg::POS_W-1:0];
                        exec_write           = 1'b1;
                    end
                end
                wpt_pkg::KIND_CHECK:
                begin
                    exec_status = wpt_pkg::STATUS_OK;
                    exec_entry  = tbl_rdata;
                    exec_write  = 1'b1;
                    if (!tbl_rdata.wrap)
                    begin
                        if (pos_reg >= tbl_rdata.threshold)
                        begin
                            exec_entry.trig = 1'b1;
                        end
                    end
                    else if (pos_reg < tbl_rdata.threshold)
                    begin
                        // position has come round past zero
                        exec_entry.wrap = 1'b0;
                    end
                end
                wpt_pkg::KIND_CLEAR:
                begin
                    exec_status     = wpt_pkg::STATUS_OK;
                    exec_entry      = tbl_rdata;
                    exec_entry.trig = 1'b0;
                    exec_write      = 1'b1;
                end
                default:
                begin
                    exec_status = wpt_pkg::STATUS_NOT_PERMITTED;
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Sequencer: next state
    //------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wpt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = wpt_pkg::ST_EXEC;
                end
            end
            wpt_pkg::ST_EXEC:
            begin
                state_next = exec_div ? wpt_pkg::ST_DIV : wpt_pkg::ST_RESP;
            end
            wpt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = wpt_pkg::ST_RESP;
                end
            end
            wpt_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = wpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wpt_pkg::ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Sequencer: outputs
    //------------------------------------------------------------------
    always_comb
    begin
        s_tready        = 1'b0;
        div_start       = 1'b0;
        load_res        = 1'b0;
        load_out        = 1'b0;
        tbl_wr.en       = 1'b0;
        tbl_wr.addr     = idx_reg[wpt_pkg::IDX_W-1:0];
        tbl_wr.entry    = exec_entry;
        res_status_next = exec_status;
        res_entry_next  = exec_entry;
        unique case (state_reg)
            wpt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            wpt_pkg::ST_EXEC:
            begin
                div_start = exec_div;
                load_res  = !exec_div;
                tbl_wr.en = exec_write;
            end
            wpt_pkg::ST_DIV:
            begin
                // wrapped threshold: remainder, wrap-pending set, trigger kept
                tbl_wr.entry.threshold = div_rem;
                tbl_wr.entry.wrap      = 1'b1;
                tbl_wr.entry.trig      = tbl_rdata.trig;
                tbl_wr.en              = div_done;
                load_res               = div_done;
                res_status_next        = wpt_pkg::STATUS_OK;
                res_entry_next         = tbl_wr.entry;
            end
            wpt_pkg::ST_RESP:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // word capture; the 33-bit sum is formed here so it never wraps
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            idx_reg  <= s_tdata[3:0];
            sum_reg  <= {1'b0, s_tdata[35:4]} + {1'b0, s_tdata[67:36]};
            offs_reg <= s_tdata[67:36];
            pos_reg  <= s_tdata[99:68];
        end
        if (load_res)
        begin
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
        end
        if (load_out)
        begin
            out_data_reg <= {4'b0000, res_entry_reg.threshold, res_entry_reg.wrap,
                             res_entry_reg.trig, res_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    `WPT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, accept, !s_tready,
                     "second word taken while one is in flight")
    `WPT_ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_done,
                     state_reg == wpt_pkg::ST_DIV,
                     "remainder finished outside the divide state")
    `WPT_ASSERT_SAME(a_no_idle_write, clk, rst_n, tbl_wr.en,
                     state_reg == wpt_pkg::ST_EXEC || state_reg == wpt_pkg::ST_DIV,
                     "entry store written while no word is in flight")

endmodule
